FILE: sv/mbsdt_pkg.sv
// Shared codes and helpers for the Modbus slave data tables block.
// Holds function codes, table reset values and mask helpers; no dependencies.
package mbsdt_pkg;

  // Request function codes
  localparam logic [2:0] FUNC_READ_COILS     = 3'd0;
  localparam logic [2:0] FUNC_WRITE_COILS    = 3'd1;
  localparam logic [2:0] FUNC_READ_DISCRETES = 3'd2;
  localparam logic [2:0] FUNC_READ_INPUT_REG = 3'd3;
  localparam logic [2:0] FUNC_READ_HOLDING   = 3'd4;
  localparam logic [2:0] FUNC_WRITE_HOLDING  = 3'd5;
  localparam logic [2:0] FUNC_SAMPLE_PINS    = 3'd6;

  // Result status codes
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_ILLEGAL_ADR = 1'b1;

  // Most words a holding read emits
  localparam int unsigned RESULT_LIMIT = 8;

  // Low n bits set, saturating at the full 16-bit word
  function automatic logic [15:0] mask16(input logic [15:0] n);
    logic [15:0] m;
    if (n >= 16'd16) begin
      m = 16'hFFFF;
    end else begin
      m = (16'd1 << n[3:0]) - 16'd1;
    end
    return m;
  endfunction

  // Holding table value after reset, entries beyond the eighth are zero
  function automatic logic [15:0] holding_init(input logic [5:0] idx);
    logic [15:0] w;
    case (idx)
      6'd0:    w = 16'hFFFF;
      6'd1:    w = 16'hFFFF;
      6'd2:    w = 16'hFFFF;
      6'd3:    w = 16'hFFFF;
      6'd4:    w = 16'h1EB8;
      6'd5:    w = 16'h4055;
      6'd6:    w = 16'h147B;
      6'd7:    w = 16'h408E;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/modbus_slave_data_tables_core.sv
// Modbus slave data store: coil, discrete-input and holding-register tables.
// Depends on mbsdt_pkg for function codes, reset table values and masks.

// Issue a request by raising start_i while busy_o is low; the item is taken at
// that clock edge. Every request answers with one or more results, each shown
// for exactly one cycle with valid_o high; the receiver cannot stall them, so
// sample every cycle. A single-result request answers in the cycle after it is
// taken and a new item may be taken in that same cycle, so the block sustains
// one item per cycle for those. A holding read of n words (n at most 8) reads
// the holding memory once per cycle, emits one word per cycle in the cycles
// after acceptance and holds busy_o high until its final word is read, so no
// new item is taken while it runs; the holding memory has a single read port.
// Addresses are 1-based and range checked against the table size (one entry
// for input-register reads); a failed check gives one result with status 1 and
// changes nothing. coil_image_o shows the coil table as it stands after the
// item that the current result belongs to. Holding entries read their reset
// values until first written; no clearing pass runs after reset.
module modbus_slave_data_tables_core
  import mbsdt_pkg::*;
#(
  parameter int unsigned COIL_COUNT    = 11,
  parameter int unsigned INPUT_COUNT   = 8,
  parameter int unsigned HOLDING_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  func_i,
  input  logic [15:0] address_i,
  input  logic [15:0] count_i,
  input  logic [15:0] write_data_i,
  input  logic [15:0] pin_levels_i,
  output logic        valid_o,
  output logic        status_o,
  output logic [15:0] read_data_o,
  output logic        last_o,
  output logic [15:0] coil_image_o
);

  localparam int unsigned AW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
  localparam logic [15:0] COIL_MASK  = mask16(16'(COIL_COUNT));
  localparam logic [15:0] INPUT_MASK = mask16(16'(INPUT_COUNT));
  localparam logic [16:0] COIL_SIZE  = 17'(COIL_COUNT);
  localparam logic [16:0] INPUT_SIZE = 17'(INPUT_COUNT);
  localparam logic [16:0] HOLD_SIZE  = 17'(HOLDING_COUNT);

  typedef enum logic {S_IDLE, S_HREAD} state_e;

  state_e      state_q;
  logic [15:0] coil_q, coil_d;
  logic [15:0] input_q, input_d;

  // Holding read sequencer
  logic [AW-1:0] idx_q;
  logic [2:0]    left_q;

  // Result stage
  logic        valid_q, status_q, last_q, from_mem_q;
  logic [15:0] data_q;

  // Holding memory, its valid bits and its registered read port
  logic [15:0]              hold_mem [HOLDING_COUNT];
  logic [HOLDING_COUNT-1:0] hvalid_q;
  logic [15:0]              rd_data_q;
  logic                     rd_valid_q;
  logic [AW-1:0]            rd_idx_q;

  logic        accept, busy;
  logic [15:0] start16;
  logic [3:0]  sh;
  logic [16:0] span;
  logic        addr_nz;
  logic        res_ok;
  logic [15:0] res_data;
  logic        hread_go;
  logic [2:0]  hread_left;
  logic        mem_we;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0] wmask;
  logic [15:0] mem_word;

  assign busy    = (state_q == S_HREAD);
  assign busy_o  = busy;
  assign accept  = start_i && !busy;
  assign start16 = address_i - 16'd1;
  assign sh      = start16[3:0];
  assign span    = {1'b0, start16} + {1'b0, count_i};
  assign addr_nz = (address_i != 16'd0);
  assign wmask   = (mask16(count_i) << sh) & COIL_MASK;

  // Decode the item: range check, read window, table updates
  always_comb begin
    res_ok     = 1'b1;
    res_data   = 16'd0;
    coil_d     = coil_q;
    input_d    = input_q;
    hread_go   = 1'b0;
    mem_we     = 1'b0;
    hread_left = (count_i >= 16'(RESULT_LIMIT)) ? 3'(RESULT_LIMIT - 1)
                                                : (count_i[2:0] - 3'd1);
    case (func_i)
      FUNC_READ_COILS: begin
        res_ok = addr_nz && (span <= COIL_SIZE);
        if (res_ok) begin
          res_data = (coil_q >> sh) & mask16(count_i);
        end
      end
      FUNC_WRITE_COILS: begin
        res_ok = addr_nz && (span <= COIL_SIZE);
        if (res_ok) begin
          coil_d = (coil_q & ~wmask) | ((write_data_i << sh) & wmask);
        end
      end
      FUNC_READ_DISCRETES: begin
        res_ok = addr_nz && (span <= INPUT_SIZE);
        if (res_ok) begin
          res_data = (input_q >> sh) & mask16(count_i);
        end
      end
      FUNC_READ_INPUT_REG: begin
        res_ok = addr_nz && (span <= 17'd1);
        if (res_ok && count_i != 16'd0) begin
          res_data = input_q;
        end
      end
      FUNC_READ_HOLDING: begin
        res_ok   = addr_nz && (span <= HOLD_SIZE);
        hread_go = res_ok && (count_i != 16'd0);
      end
      FUNC_WRITE_HOLDING: begin
        res_ok = addr_nz && (span <= HOLD_SIZE);
        mem_we = res_ok && (count_i != 16'd0);
      end
      FUNC_SAMPLE_PINS: begin
        input_d = pin_levels_i & INPUT_MASK;
      end
      default: begin
        // unused code: answer ok with no data
      end
    endcase
  end

  assign rd_en   = (accept && hread_go) || busy;
  assign rd_addr = busy ? idx_q : start16[AW-1:0];

  // Holding memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      hold_mem[start16[AW-1:0]] <= write_data_i;
    end
    if (rd_en) begin
      rd_data_q <= hold_mem[rd_addr];
      rd_idx_q  <= rd_addr;
    end
  end

  // Valid bits: an entry never written reads as its reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q   <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (accept && mem_we) begin
        hvalid_q[start16[AW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= hvalid_q[rd_addr];
      end
    end
  end

  // Sequencer, tables and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      coil_q     <= '0;
      input_q    <= '0;
      idx_q      <= '0;
      left_q     <= '0;
      valid_q    <= 1'b0;
      status_q   <= STATUS_OK;
      last_q     <= 1'b0;
      from_mem_q <= 1'b0;
      data_q     <= '0;
    end else begin
      valid_q <= 1'b0;
      if (busy) begin
        // advance one word per cycle, drop busy on the final read
        valid_q    <= 1'b1;
        status_q   <= STATUS_OK;
        from_mem_q <= 1'b1;
        last_q     <= (left_q == 3'd1);
        idx_q      <= idx_q + AW'(1);
        left_q     <= left_q - 3'd1;
        if (left_q == 3'd1) begin
          state_q <= S_IDLE;
        end
      end else if (accept) begin
        coil_q     <= coil_d;
        input_q    <= input_d;
        valid_q    <= 1'b1;
        status_q   <= res_ok ? STATUS_OK : STATUS_ILLEGAL_ADR;
        data_q     <= res_data;
        from_mem_q <= hread_go;
        last_q     <= !hread_go || (hread_left == 3'd0);
        if (hread_go && hread_left != 3'd0) begin
          state_q <= S_HREAD;
          idx_q   <= start16[AW-1:0] + AW'(1);
          left_q  <= hread_left;
        end
      end
    end
  end

  assign mem_word     = rd_valid_q ? rd_data_q : holding_init(6'(rd_idx_q));
  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign last_o       = last_q;
  assign read_data_o  = from_mem_q ? mem_word : data_q;
  assign coil_image_o = coil_q;

endmodule
